// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked on every rising clk_i edge outside reset
`define SFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Same check, also evaluated while reset is asserted
`define SFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SFP_ASSERT(lbl, prop, msg)
`define SFP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: rtl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Constants and the result layout of the sensor frame parser.
// ----------------------------------------------------------------------------
package sfp_pkg;

  // Frame format
  localparam logic [7:0] SyncByte  = 8'h5A;
  localparam int unsigned FrameLen = 20;
  localparam int unsigned SumPos   = 19;
  localparam int unsigned DataFirst = 4;                       // first decoded byte
  localparam int unsigned DataBytes = SumPos - DataFirst;      // bytes 4..18
  localparam int unsigned PosW     = $clog2(FrameLen);

  typedef logic [PosW-1:0] pos_t;

  // Position codes with a meaning of their own
  localparam pos_t PosSync0 = pos_t'(0);
  localparam pos_t PosSync1 = pos_t'(1);
  localparam pos_t PosSum   = pos_t'(SumPos);

  // Result item, last field (status) in the lowest bits, padded to whole bytes
  typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] altitude;
    logic [31:0] gas_resistance;
    logic [11:0] iaq_index;
    logic [3:0]  aq_acc;
    logic [23:0] pressure;
    logic [15:0] humidity;
    logic [15:0] temperature;
    logic        status;
  } result_t;

  localparam int unsigned OutDataW = $bits(result_t);

  localparam logic StatusOk  = 1'b0;
  localparam logic StatusErr = 1'b1;

endpackage

// File: rtl/sensor_frame_parser_unit.sv
// Output: the result of a frame is on m_axis_tvalid in the cycle after its checksum byte is taken.
// Throughput: one byte per cycle; input stalls only while a result waits unaccepted.
// A single output register holds the result; the input side keeps taking bytes otherwise.
// Reset (rst_ni low, asynchronous): hunt restarts at byte 0, sum cleared, output empty.
// ----------------------------------------------------------------------------
// sensor_frame_parser_unit
// Finds 0x5A 0x5A framed 20-byte sensor frames, checks the sum8 checksum and
// emits the decoded big-endian fields, or an error status on mismatch.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sensor_frame_parser_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input item: [7:0] rx_byte
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,
  // result item: [0] status, [16:1] temperature, [32:17] humidity,
  // [56:33] pressure, [60:57] aq_acc, [72:61] iaq_index,
  // [104:73] gas_resistance, [120:105] altitude, [127:121] zero
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [sfp_pkg::OutDataW-1:0] m_axis_tdata
);

  sfp_pkg::pos_t    pos_q, pos_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       data_q [sfp_pkg::DataBytes];
  logic             out_valid_q, out_valid_d;
  sfp_pkg::result_t out_q, out_d;

  logic             in_acc;
  sfp_pkg::pos_t    pos_eff;
  logic             is_sync;
  logic             store;
  logic             close;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_sync       = (s_axis_tdata == sfp_pkg::SyncByte);

  // out-of-range position behaves as the start of a frame
  assign pos_eff = (pos_q >= sfp_pkg::pos_t'(sfp_pkg::FrameLen)) ? sfp_pkg::PosSync0 : pos_q;

  assign store = in_acc && (pos_eff < sfp_pkg::PosSum) &&
                 !((pos_eff == sfp_pkg::PosSync0 || pos_eff == sfp_pkg::PosSync1) && !is_sync);
  assign close = in_acc && (pos_eff == sfp_pkg::PosSum);

  // position and running sum
  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (in_acc) begin
      if (pos_eff == sfp_pkg::PosSync0 && !is_sync) begin
        pos_d = sfp_pkg::PosSync0;
      end else if (pos_eff == sfp_pkg::PosSync1 && !is_sync) begin
        pos_d = sfp_pkg::PosSync0;
        sum_d = '0;
      end else if (close) begin
        pos_d = sfp_pkg::PosSync0;
        sum_d = '0;
      end else begin
        pos_d = pos_eff + sfp_pkg::pos_t'(1);
        sum_d = (pos_eff == sfp_pkg::PosSync0) ? s_axis_tdata : sum_q + s_axis_tdata;
      end
    end
  end

  // decode of the stored bytes; data_q[0] holds byte 4, data_q[14] byte 18
  always_comb begin
    out_d = '0;
    if (s_axis_tdata != sum_q) begin
      out_d.status = sfp_pkg::StatusErr;
    end else begin
      out_d.status         = sfp_pkg::StatusOk;
      out_d.temperature    = {data_q[0], data_q[1]};
      out_d.humidity       = {data_q[2], data_q[3]};
      out_d.pressure       = {data_q[4], data_q[5], data_q[6]};
      out_d.aq_acc         = data_q[7][7:4];
      out_d.iaq_index      = {data_q[7][3:0], data_q[8]};
      out_d.gas_resistance = {data_q[9], data_q[10], data_q[11], data_q[12]};
      out_d.altitude       = {data_q[13], data_q[14]};
    end
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (close) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= sfp_pkg::PosSync0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // frame bytes: shift line, the last DataBytes stored bytes are bytes 4..18
  always_ff @(posedge clk_i) begin
    if (store) begin
      for (int i = 0; i < int'(sfp_pkg::DataBytes) - 1; i++) begin
        data_q[i] <= data_q[i+1];
      end
      data_q[sfp_pkg::DataBytes-1] <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (close) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // checks
  `SFP_ASSERT(a_pos_range, pos_q < sfp_pkg::pos_t'(sfp_pkg::FrameLen),
              "byte position out of range")
  `SFP_ASSERT(a_close_gives_result,
              close |=> (m_axis_tvalid && pos_q == sfp_pkg::PosSync0 && sum_q == 8'h00),
              "checksum byte gave no result")
  `SFP_ASSERT(a_bad_second_restarts,
              (in_acc && pos_q == sfp_pkg::PosSync1 && !is_sync) |=>
                (pos_q == sfp_pkg::PosSync0 && sum_q == 8'h00),
              "bad second sync byte did not restart")
  `SFP_ASSERT(a_err_fields_zero,
              (m_axis_tvalid && out_q.status == sfp_pkg::StatusErr) |->
                (out_q[sfp_pkg::OutDataW-1:1] == '0),
              "error result carries data")
  `SFP_ASSERT(a_no_accept_when_blocked, (out_valid_q && !m_axis_tready) |-> !s_axis_tready,
              "input taken while result stalled")

endmodule
